// ----- src/ile_pkg.sv -----
// ile_pkg: request, status and sequencer state codes for the indexed list engine.
// No dependencies; imported by ile_seq and indexed_list_engine_top.
package ile_pkg;

   localparam int REQ_TYPE_W = 3;
   localparam int STATUS_W   = 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_GET    = 3'd4,
      OP_SET    = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_BAD_INDEX = 2'd1,
      STS_UNDERFLOW = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_READ_WAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

endpackage

// ----- src/ile_store.sv -----
// ile_store: entry memory, one write port and one registered read port.
// Depends on nothing; instantiated by indexed_list_engine_top.
module ile_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ile_seq.sv -----
// ile_seq: request sequencer with index counter, entry count and result register.
// Depends on ile_pkg; drives the ports of ile_store.
module ile_seq #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32,
   parameter int AW         = 4,
   parameter int CW         = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ile_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [CW-1:0]               req_position,
   input  logic [WORD_WIDTH-1:0]       req_write_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ile_pkg::STATUS_W-1:0] rsp_status,
   output logic [WORD_WIDTH-1:0]       rsp_read_word,
   output logic [CW-1:0]               rsp_list_size,
   output logic                        wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [WORD_WIDTH-1:0]       wr_data,
   output logic [AW-1:0]               rd_addr,
   input  logic [WORD_WIDTH-1:0]       rd_data
);
   import ile_pkg::*;

   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [CW-1:0]         pos_ff;
   logic [WORD_WIDTH-1:0] word_ff;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         count_ff, count_in;
   status_type            status_ff, status_in;
   logic [WORD_WIDTH-1:0] rdw_ff, rdw_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff;
   logic [WORD_WIDTH-1:0] rsp_word_ff;
   logic [CW-1:0]         rsp_size_ff;
   logic                  accept, rsp_load;
   logic [CW-1:0]         count_dec, count_inc, idx_dec, idx_inc;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign count_dec = count_ff - 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign idx_dec   = idx_ff - 1'b1;
   assign idx_inc   = idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_type);
         pos_ff  <= req_position;
         word_ff <= req_write_word;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rdw_ff    <= rdw_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_word_ff   <= rdw_ff;
         rsp_size_ff   <= count_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      rdw_in       = rdw_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = word_ff;
      rd_addr      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            status_in = STS_OK;
            rdw_in    = '0;
            state_in  = S_FINISH;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff == CAP_CNT) begin
                     status_in = STS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     count_in = count_inc;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = STS_UNDERFLOW;
                  end else begin
                     rd_addr  = count_dec[AW-1:0];
                     count_in = count_dec;
                     state_in = S_READ_WAIT;
                  end
               end
               OP_INSERT: begin
                  if (pos_ff > count_ff) begin
                     status_in = STS_BAD_INDEX;
                  end else if (count_ff == CAP_CNT) begin
                     status_in = STS_FULL;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHIFT_RD;
                  end
               end
               OP_REMOVE, OP_GET: begin
                  if (pos_ff >= count_ff) begin
                     status_in = STS_BAD_INDEX;
                  end else begin
                     rd_addr  = pos_ff[AW-1:0];
                     idx_in   = pos_ff;
                     state_in = S_READ_WAIT;
                  end
               end
               OP_SET: begin
                  if (pos_ff >= count_ff) begin
                     status_in = STS_BAD_INDEX;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = pos_ff[AW-1:0];
                  end
               end
               default: begin
                  status_in = STS_BAD_INDEX;
               end
            endcase
         end
         S_READ_WAIT: begin
            rdw_in   = rd_data;
            state_in = (op_ff == OP_REMOVE) ? S_SHIFT_RD : S_FINISH;
         end
         S_SHIFT_RD: begin
            if (op_ff == OP_INSERT) begin
               if (idx_ff > pos_ff) begin
                  rd_addr  = idx_dec[AW-1:0];
                  state_in = S_SHIFT_WR;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = pos_ff[AW-1:0];
                  count_in = count_inc;
                  state_in = S_FINISH;
               end
            end else begin
               if (idx_inc < count_ff) begin
                  rd_addr  = idx_inc[AW-1:0];
                  state_in = S_SHIFT_WR;
               end else begin
                  count_in = count_dec;
                  state_in = S_FINISH;
               end
            end
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[AW-1:0];
            wr_data  = rd_data;
            idx_in   = (op_ff == OP_INSERT) ? idx_dec : idx_inc;
            state_in = S_SHIFT_RD;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_list_size = rsp_size_ff;

endmodule

// ----- src/indexed_list_engine_top.sv -----
// Each accepted request runs through the sequencer states: push, set and failed requests go
// from decide to finish, get and pop add a read wait, insert moves each entry from the position
// up and remove reads, then moves each entry above the position down, one entry at a time
// through the single port pair of the memory. One request in flight; the next request beat is
// taken once the result is loaded into the result register, even while that beat is stalled.
// Reset clears the entry count and control state only. Uses ile_pkg, ile_store, ile_seq.
module indexed_list_engine_top #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32,
   parameter int CW         = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ile_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [CW-1:0]                  req_position,
   input  logic [WORD_WIDTH-1:0]          req_write_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ile_pkg::STATUS_W-1:0]   rsp_status,
   output logic [WORD_WIDTH-1:0]          rsp_read_word,
   output logic [CW-1:0]                  rsp_list_size
);
   import ile_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;

   ile_seq #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_write_word (req_write_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_word  (rsp_read_word),
      .rsp_list_size  (rsp_list_size),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   ile_store #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
